// File: design/tick_timers_debounce_blinker_assert.svh
// Assertion macros for the checker file.
`ifndef TICK_TIMERS_DEBOUNCE_BLINKER_ASSERT_SVH
`define TICK_TIMERS_DEBOUNCE_BLINKER_ASSERT_SVH

// Checked on every rising edge outside reset.
`define TTDB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising edge, reset included.
`define TTDB_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: design/ttdb_pkg.sv
`timescale 1ns / 1ps
package ttdb_pkg;

	// APB address width: eight 32-bit registers
	localparam int ADDR_W = 5;

	// Request codes
	typedef enum logic [2:0] {
		ACT_TICK          = 3'd0,
		ACT_START_TIMEOUT = 3'd1,
		ACT_ACK_FLAGS     = 3'd2,
		ACT_START_BLINK   = 3'd3,
		ACT_ACK_BUTTON    = 3'd4
	} action_t;

	// Register map, word index
	typedef enum logic [2:0] {
		REG_PERIOD_A = 3'd0,
		REG_PERIOD_B = 3'd1,
		REG_PERIOD_C = 3'd2,
		REG_DEBOUNCE = 3'd3,
		REG_REPEAT   = 3'd4,
		REG_ON       = 3'd5,
		REG_OFF      = 3'd6,
		REG_FOREVER  = 3'd7
	} reg_idx_t;

	// Register reset values
	localparam logic [15:0] RST_PERIOD_A = 16'd250;
	localparam logic [15:0] RST_PERIOD_B = 16'd500;
	localparam logic [15:0] RST_PERIOD_C = 16'd1000;
	localparam logic [7:0]  RST_DEBOUNCE = 8'd30;
	localparam logic [7:0]  RST_REPEAT   = 8'd150;
	localparam logic [15:0] RST_ON       = 16'd50;
	localparam logic [15:0] RST_OFF      = 16'd200;
	localparam logic        RST_FOREVER  = 1'b1;

	typedef struct packed {
		logic [2:0]  action;
		logic        button_level;
		logic [1:0]  timeout_select;
		logic [15:0] timeout_length;
		logic [2:0]  flag_clear_mask;
		logic        blink_led;
		logic [7:0]  blink_count;
	} cmd_t;

	typedef struct packed {
		logic [2:0]  period_flags;
		logic [2:0]  timeouts_done;
		logic        button_pressed;
		logic [15:0] press_time;
		logic        repeat_ready;
		logic        red_light;
		logic        green_light;
	} rsp_t;

endpackage

// File: design/tick_timers_debounce_blinker.sv
`timescale 1ns / 1ps
// Channel   Signals                          Direction  Moves
// cmd       cmd_valid / cmd_ready / cmd      in         one request (tick or event)
// rsp       rsp_valid / rsp_ready / rsp      out        status after that request
// apb       psel penable pwrite paddr ...    in/out     register writes and reads
//
// One request per cycle while rsp_ready stays high; request register, then result register.
// Every request is handled in a single pass of counters and compares in stage 1.
// rsp_ready low holds the result; stage 1 takes one request if empty, then cmd_ready drops.
// arst_n resets block state and loads the register reset values; no clearing pass is needed.
module tick_timers_debounce_blinker
	import ttdb_pkg::*;
#(
	parameter int NUM_TIMEOUTS = 3,
	parameter int COUNT_WIDTH  = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cmd_valid,
	output logic              cmd_ready,
	input  cmd_t              cmd,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int CMP_W = (COUNT_WIDTH > 16) ? COUNT_WIDTH : 16;
	localparam int TO_W  = (NUM_TIMEOUTS > 3) ? NUM_TIMEOUTS : 3;
	localparam logic [COUNT_WIDTH-1:0] CNT_MAX = {COUNT_WIDTH{1'b1}};

	// Configuration registers
	logic [15:0] period_q [3];
	logic [7:0]  debounce_q;
	logic [7:0]  repeat_ticks_q;
	logic [15:0] on_q;
	logic [15:0] off_q;
	logic        forever_q;

	// Block state
	logic [COUNT_WIDTH-1:0]  per_cnt_q [3];
	logic [COUNT_WIDTH-1:0]  per_cnt_d [3];
	logic [2:0]              flags_q, flags_d;
	logic [COUNT_WIDTH-1:0]  to_cnt_q [NUM_TIMEOUTS];
	logic [COUNT_WIDTH-1:0]  to_cnt_d [NUM_TIMEOUTS];
	logic [15:0]             to_len_q [NUM_TIMEOUTS];
	logic [15:0]             to_len_d [NUM_TIMEOUTS];
	logic [NUM_TIMEOUTS-1:0] to_done_q, to_done_d;
	logic [TO_W-1:0]         to_done_ext;
	logic [7:0]              low_run_q, low_run_d;
	logic [7:0]              high_run_q, high_run_d;
	logic                    pressed_q, pressed_d;
	logic [15:0]             press_q, press_d;
	logic [7:0]              rep_cnt_q, rep_cnt_d;
	logic                    rep_flag_q, rep_flag_d;
	logic [COUNT_WIDTH-1:0]  ph_cnt_q [2];
	logic [COUNT_WIDTH-1:0]  ph_cnt_d [2];
	logic [7:0]              bdone_q [2];
	logic [7:0]              bdone_d [2];
	logic [7:0]              btgt_q [2];
	logic [7:0]              btgt_d [2];
	logic [1:0]              bact_q, bact_d;
	logic                    phase_on_q, phase_on_d;
	logic [1:0]              light_q, light_d;

	// Pipeline
	logic valid_s1;
	cmd_t cmd_s1;
	logic rsp_valid_q;
	rsp_t rsp_q, rsp_d;
	logic adv, step, cfg_wr;

	// Handshake: the result register parts the two sides
	assign adv       = !rsp_valid_q || rsp_ready;
	assign cmd_ready = !valid_s1 || adv;
	assign step      = valid_s1 && adv;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cmd_ready)
				valid_s1 <= cmd_valid;
			if (adv)
				rsp_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid && cmd_ready)
			cmd_s1 <= cmd;
		if (step)
			rsp_q <= rsp_d;
	end

	// APB register file
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			period_q[0]    <= RST_PERIOD_A;
			period_q[1]    <= RST_PERIOD_B;
			period_q[2]    <= RST_PERIOD_C;
			debounce_q     <= RST_DEBOUNCE;
			repeat_ticks_q <= RST_REPEAT;
			on_q           <= RST_ON;
			off_q          <= RST_OFF;
			forever_q      <= RST_FOREVER;
		end else if (cfg_wr) begin
			case (reg_idx_t'(paddr[ADDR_W-1:2]))
				REG_PERIOD_A: period_q[0]    <= pwdata[15:0];
				REG_PERIOD_B: period_q[1]    <= pwdata[15:0];
				REG_PERIOD_C: period_q[2]    <= pwdata[15:0];
				REG_DEBOUNCE: debounce_q     <= pwdata[7:0];
				REG_REPEAT:   repeat_ticks_q <= pwdata[7:0];
				REG_ON:       on_q           <= pwdata[15:0];
				REG_OFF:      off_q          <= pwdata[15:0];
				REG_FOREVER:  forever_q      <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx_t'(paddr[ADDR_W-1:2]))
			REG_PERIOD_A: prdata = {16'd0, period_q[0]};
			REG_PERIOD_B: prdata = {16'd0, period_q[1]};
			REG_PERIOD_C: prdata = {16'd0, period_q[2]};
			REG_DEBOUNCE: prdata = {24'd0, debounce_q};
			REG_REPEAT:   prdata = {24'd0, repeat_ticks_q};
			REG_ON:       prdata = {16'd0, on_q};
			REG_OFF:      prdata = {16'd0, off_q};
			REG_FOREVER:  prdata = {31'd0, forever_q};
			default:      prdata = 32'd0;
		endcase
	end

	// Stage 1: next state for the request in the request register
	always_comb begin
		per_cnt_d  = per_cnt_q;
		flags_d    = flags_q;
		to_cnt_d   = to_cnt_q;
		to_len_d   = to_len_q;
		to_done_d  = to_done_q;
		low_run_d  = low_run_q;
		high_run_d = high_run_q;
		pressed_d  = pressed_q;
		press_d    = press_q;
		rep_cnt_d  = rep_cnt_q;
		rep_flag_d = rep_flag_q;
		ph_cnt_d   = ph_cnt_q;
		bdone_d    = bdone_q;
		btgt_d     = btgt_q;
		bact_d     = bact_q;
		phase_on_d = phase_on_q;
		light_d    = light_q;

		case (action_t'(cmd_s1.action))
			ACT_TICK: begin
				// periodic flags
				for (int k = 0; k < 3; k++) begin
					if (per_cnt_d[k] != CNT_MAX)
						per_cnt_d[k] = per_cnt_d[k] + 1'b1;
					if (CMP_W'(per_cnt_d[k]) >= CMP_W'(period_q[k])) begin
						per_cnt_d[k] = '0;
						flags_d[k]   = 1'b1;
					end
				end
				// one-shot timeouts
				for (int i = 0; i < NUM_TIMEOUTS; i++) begin
					if (!to_done_q[i]) begin
						if (to_cnt_d[i] != CNT_MAX)
							to_cnt_d[i] = to_cnt_d[i] + 1'b1;
						if (CMP_W'(to_cnt_d[i]) >= CMP_W'(to_len_q[i]))
							to_done_d[i] = 1'b1;
					end
				end
				// debounce, active-low pin
				if (!cmd_s1.button_level) begin
					if (low_run_d != 8'hFF)
						low_run_d = low_run_d + 8'd1;
					high_run_d = 8'd0;
					if (low_run_d >= debounce_q)
						pressed_d = 1'b1;
				end else begin
					if (high_run_d != 8'hFF)
						high_run_d = high_run_d + 8'd1;
					low_run_d = 8'd0;
					if (high_run_d >= debounce_q)
						pressed_d = 1'b0;
				end
				// press time
				if (pressed_d && press_d != 16'hFFFF)
					press_d = press_d + 16'd1;
				// repeat delay, wrapping counter
				if (!rep_flag_q) begin
					rep_cnt_d = rep_cnt_q + 8'd1;
					if (rep_cnt_d == repeat_ticks_q) begin
						rep_cnt_d  = 8'd0;
						rep_flag_d = 1'b1;
					end
				end
				// blinkers: red first, green sees the phase red left
				for (int k = 0; k < 2; k++) begin
					if (bact_d[k]) begin
						if (ph_cnt_d[k] != CNT_MAX)
							ph_cnt_d[k] = ph_cnt_d[k] + 1'b1;
						if (phase_on_d) begin
							if (CMP_W'(ph_cnt_d[k]) >= CMP_W'(on_q)) begin
								phase_on_d  = 1'b0;
								ph_cnt_d[k] = '0;
								light_d     = 2'b00;
							end
						end else if (CMP_W'(ph_cnt_d[k]) >= CMP_W'(off_q)) begin
							if (bdone_d[k] != 8'hFF)
								bdone_d[k] = bdone_d[k] + 8'd1;
							phase_on_d  = 1'b1;
							ph_cnt_d[k] = '0;
							if (bdone_d[k] >= btgt_d[k] && !forever_q) begin
								bact_d[k]  = 1'b0;
								bdone_d[k] = 8'd0;
							end else begin
								light_d[k] = 1'b1;
							end
						end
					end
				end
			end
			ACT_START_TIMEOUT: begin
				// a select beyond the timeout count matches none
				for (int i = 0; i < NUM_TIMEOUTS; i++) begin
					if (32'(cmd_s1.timeout_select) == i) begin
						to_len_d[i]  = cmd_s1.timeout_length;
						to_cnt_d[i]  = '0;
						to_done_d[i] = 1'b0;
					end
				end
			end
			ACT_ACK_FLAGS: begin
				flags_d = flags_q & ~cmd_s1.flag_clear_mask;
			end
			ACT_START_BLINK: begin
				bact_d[cmd_s1.blink_led]   = 1'b1;
				ph_cnt_d[cmd_s1.blink_led] = '0;
				bdone_d[cmd_s1.blink_led]  = 8'd0;
				btgt_d[cmd_s1.blink_led]   = cmd_s1.blink_count;
				phase_on_d                 = 1'b1;
				light_d[cmd_s1.blink_led]  = 1'b1;
			end
			ACT_ACK_BUTTON: begin
				press_d    = 16'd0;
				rep_cnt_d  = 8'd0;
				rep_flag_d = 1'b0;
			end
			default: ;
		endcase
	end

	// Result from the updated state
	assign to_done_ext = TO_W'(to_done_d);

	always_comb begin
		rsp_d.period_flags   = flags_d;
		rsp_d.timeouts_done  = to_done_ext[2:0];
		rsp_d.button_pressed = pressed_d;
		rsp_d.press_time     = press_d;
		rsp_d.repeat_ready   = rep_flag_d;
		rsp_d.red_light      = light_d[0];
		rsp_d.green_light    = light_d[1];
	end

	// State update once per request
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++)
				per_cnt_q[k] <= '0;
			flags_q <= 3'd0;
			for (int i = 0; i < NUM_TIMEOUTS; i++) begin
				to_cnt_q[i] <= '0;
				to_len_q[i] <= 16'd0;
			end
			to_done_q  <= '1;
			low_run_q  <= 8'd0;
			high_run_q <= 8'd0;
			pressed_q  <= 1'b0;
			press_q    <= 16'd0;
			rep_cnt_q  <= 8'd0;
			rep_flag_q <= 1'b0;
			for (int k = 0; k < 2; k++) begin
				ph_cnt_q[k] <= '0;
				bdone_q[k]  <= 8'd0;
				btgt_q[k]   <= 8'd0;
			end
			bact_q     <= 2'b00;
			phase_on_q <= 1'b1;
			light_q    <= 2'b00;
		end else if (step) begin
			per_cnt_q  <= per_cnt_d;
			flags_q    <= flags_d;
			to_cnt_q   <= to_cnt_d;
			to_len_q   <= to_len_d;
			to_done_q  <= to_done_d;
			low_run_q  <= low_run_d;
			high_run_q <= high_run_d;
			pressed_q  <= pressed_d;
			press_q    <= press_d;
			rep_cnt_q  <= rep_cnt_d;
			rep_flag_q <= rep_flag_d;
			ph_cnt_q   <= ph_cnt_d;
			bdone_q    <= bdone_d;
			btgt_q     <= btgt_d;
			bact_q     <= bact_d;
			phase_on_q <= phase_on_d;
			light_q    <= light_d;
		end
	end

endmodule

// File: design/ttdb_checker.sv
`timescale 1ns / 1ps
`include "tick_timers_debounce_blinker_assert.svh"
module ttdb_checker
	import ttdb_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	input logic cmd_ready,
	input logic rsp_valid,
	input logic rsp_ready,
	input rsp_t rsp,
	input logic pready
);

	// no result shows while reset is held
	`TTDB_ASSERT_ALWAYS(a_rst_quiet, !arst_n |-> !rsp_valid, "result valid during reset")

	// a waiting result stays put
	`TTDB_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp), "stalled result changed")

	// a sink that takes results never stalls the request side
	`TTDB_ASSERT(a_no_stall, rsp_ready && pready |-> cmd_ready, "request stalled with sink ready")

	// with the sink ready, results pass request then result register
	`TTDB_ASSERT(a_latency, (cmd_valid && cmd_ready && rsp_ready) ##1 rsp_ready |=> rsp_valid, "result late")

endmodule

bind tick_timers_debounce_blinker ttdb_checker u_ttdb_checker (.*);

// File: verif/tb_top.sv
`timescale 1ns / 1ps
module tb_top;
	import ttdb_pkg::*;

	localparam int TIMEOUTS = 3;
	localparam int CNT_W = 16;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int SETTLE_CYCLES = 4;
	localparam int MAX_WAIT = 12;
	// action codes the block ignores
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;
	// a select past the last timeout
	localparam logic [1:0] SEL_NONE = 2'd3;

	logic clk = 1'b0;
	logic arst_n;
	logic cmd_valid = 1'b0;
	logic cmd_ready;
	cmd_t cmd = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	logic psel = 1'b0;
	logic penable = 1'b0;
	logic pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	tick_timers_debounce_blinker #(
		.NUM_TIMEOUTS(TIMEOUTS),
		.COUNT_WIDTH (CNT_W)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd_ready(cmd_ready),
		.cmd      (cmd),
		.rsp_valid(rsp_valid),
		.rsp_ready(rsp_ready),
		.rsp      (rsp),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// register mirror
	logic [15:0] cfg_period [3];
	logic [7:0]  cfg_debounce, cfg_repeat;
	logic [15:0] cfg_on, cfg_off;
	logic        cfg_forever;

	// housekeeping state mirror
	logic [15:0] per_cnt [3];
	logic [2:0]  flags_q;
	logic [15:0] to_cnt [TIMEOUTS];
	logic [15:0] to_len [TIMEOUTS];
	logic [2:0]  to_done;
	logic [7:0]  low_run_q, high_run_q;
	logic        pressed_q;
	logic [15:0] press_cnt;
	logic [7:0]  rep_cnt;
	logic        rep_flag;
	logic [15:0] ph_cnt [2];
	logic [7:0]  blinks [2];
	logic [7:0]  blink_tgt [2];
	logic        blink_on [2];
	logic        phase_lit;
	logic [1:0]  lights;

	rsp_t pending_status [$];
	int mismatches = 0;
	int requests_sent = 0;
	int ticks_sent = 0;
	int status_checked = 0;
	int settings_used = 0;
	int idle_cycles = 0;
	int rsp_hold = 0;
	bit steady = 1'b0;
	bit vld_want = 1'b0;
	logic pin_level = 1'b1;

	function automatic void reset_model();
		int k;
		cfg_period[0] = RST_PERIOD_A;
		cfg_period[1] = RST_PERIOD_B;
		cfg_period[2] = RST_PERIOD_C;
		cfg_debounce = RST_DEBOUNCE;
		cfg_repeat = RST_REPEAT;
		cfg_on = RST_ON;
		cfg_off = RST_OFF;
		cfg_forever = RST_FOREVER;
		for (k = 0; k < 3; k++) per_cnt[k] = '0;
		for (k = 0; k < TIMEOUTS; k++) begin
			to_cnt[k] = '0;
			to_len[k] = '0;
		end
		flags_q = '0;
		to_done = '1;
		low_run_q = '0;
		high_run_q = '0;
		pressed_q = 1'b0;
		press_cnt = '0;
		rep_cnt = '0;
		rep_flag = 1'b0;
		for (k = 0; k < 2; k++) begin
			ph_cnt[k] = '0;
			blinks[k] = '0;
			blink_tgt[k] = '0;
			blink_on[k] = 1'b0;
		end
		phase_lit = 1'b1;
		lights = '0;
	endfunction

	function automatic void set_cfg(reg_idx_t idx, logic [31:0] v);
		case (idx)
			REG_PERIOD_A: cfg_period[0] = v[15:0];
			REG_PERIOD_B: cfg_period[1] = v[15:0];
			REG_PERIOD_C: cfg_period[2] = v[15:0];
			REG_DEBOUNCE: cfg_debounce = v[7:0];
			REG_REPEAT:   cfg_repeat = v[7:0];
			REG_ON:       cfg_on = v[15:0];
			REG_OFF:      cfg_off = v[15:0];
			REG_FOREVER:  cfg_forever = v[0];
			default: ;
		endcase
	endfunction

	function automatic logic [31:0] cfg_value(reg_idx_t idx);
		case (idx)
			REG_PERIOD_A: return 32'(cfg_period[0]);
			REG_PERIOD_B: return 32'(cfg_period[1]);
			REG_PERIOD_C: return 32'(cfg_period[2]);
			REG_DEBOUNCE: return 32'(cfg_debounce);
			REG_REPEAT:   return 32'(cfg_repeat);
			REG_ON:       return 32'(cfg_on);
			REG_OFF:      return 32'(cfg_off);
			default:      return 32'(cfg_forever);
		endcase
	endfunction

	// one blinker; the on/off phase bit is shared, red runs first
	function automatic void blink_tick(int k);
		if (blink_on[k]) begin
			if (ph_cnt[k] != 16'hFFFF) ph_cnt[k] = ph_cnt[k] + 16'd1;
			if (phase_lit) begin
				if (ph_cnt[k] >= cfg_on) begin
					phase_lit = 1'b0;
					ph_cnt[k] = '0;
					lights = '0;
				end
			end else if (ph_cnt[k] >= cfg_off) begin
				if (blinks[k] != 8'hFF) blinks[k] = blinks[k] + 8'd1;
				phase_lit = 1'b1;
				ph_cnt[k] = '0;
				if (blinks[k] >= blink_tgt[k] && !cfg_forever) begin
					blink_on[k] = 1'b0;
					blinks[k] = '0;
				end else begin
					lights[k] = 1'b1;
				end
			end
		end
	endfunction

	function automatic void run_tick(logic level);
		int k;
		// periodic flags
		for (k = 0; k < 3; k++) begin
			if (per_cnt[k] != 16'hFFFF) per_cnt[k] = per_cnt[k] + 16'd1;
			if (per_cnt[k] >= cfg_period[k]) begin
				per_cnt[k] = '0;
				flags_q[k] = 1'b1;
			end
		end
		// one-shot timeouts
		for (k = 0; k < TIMEOUTS; k++) begin
			if (!to_done[k]) begin
				if (to_cnt[k] != 16'hFFFF) to_cnt[k] = to_cnt[k] + 16'd1;
				if (to_cnt[k] >= to_len[k]) to_done[k] = 1'b1;
			end
		end
		// debounce, pin low means pressed
		if (!level) begin
			if (low_run_q != 8'hFF) low_run_q = low_run_q + 8'd1;
			high_run_q = '0;
			if (low_run_q >= cfg_debounce) pressed_q = 1'b1;
		end else begin
			if (high_run_q != 8'hFF) high_run_q = high_run_q + 8'd1;
			low_run_q = '0;
			if (high_run_q >= cfg_debounce) pressed_q = 1'b0;
		end
		if (pressed_q && press_cnt != 16'hFFFF) press_cnt = press_cnt + 16'd1;
		// repeat delay wraps at eight bits
		if (!rep_flag) begin
			rep_cnt = rep_cnt + 8'd1;
			if (rep_cnt == cfg_repeat) begin
				rep_cnt = '0;
				rep_flag = 1'b1;
			end
		end
		blink_tick(0);
		blink_tick(1);
	endfunction

	// advance the mirror by one request and return the status it should give
	function automatic rsp_t apply_request(cmd_t c);
		rsp_t s;
		case (c.action)
			ACT_TICK: run_tick(c.button_level);
			ACT_START_TIMEOUT: begin
				if (c.timeout_select < TIMEOUTS) begin
					to_len[c.timeout_select] = c.timeout_length;
					to_cnt[c.timeout_select] = '0;
					to_done[c.timeout_select] = 1'b0;
				end
			end
			ACT_ACK_FLAGS: flags_q = flags_q & ~c.flag_clear_mask;
			ACT_START_BLINK: begin
				blink_on[c.blink_led] = 1'b1;
				ph_cnt[c.blink_led] = '0;
				blinks[c.blink_led] = '0;
				blink_tgt[c.blink_led] = c.blink_count;
				phase_lit = 1'b1;
				lights[c.blink_led] = 1'b1;
			end
			ACT_ACK_BUTTON: begin
				press_cnt = '0;
				rep_cnt = '0;
				rep_flag = 1'b0;
			end
			default: ;
		endcase
		s.period_flags = flags_q;
		s.timeouts_done = to_done;
		s.button_pressed = pressed_q;
		s.press_time = press_cnt;
		s.repeat_ready = rep_flag;
		s.red_light = lights[0];
		s.green_light = lights[1];
		return s;
	endfunction

	function automatic int draw_wait();
		return steady ? 0 : $urandom_range(0, MAX_WAIT);
	endfunction

	function automatic void check_field(string what, logic [15:0] want, logic [15:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0h got %0h", $time, what, want, got);
			mismatches++;
		end
	endfunction

	function automatic cmd_t req(logic [2:0] act, logic level, logic [1:0] sel,
			logic [15:0] len, logic [2:0] mask, logic led, logic [7:0] count);
		cmd_t c;
		c.action = act;
		c.button_level = level;
		c.timeout_select = sel;
		c.timeout_length = len;
		c.flag_clear_mask = mask;
		c.blink_led = led;
		c.blink_count = count;
		return c;
	endfunction

	// mostly ticks with a slowly wandering pin; events carry random content
	function automatic cmd_t random_request(int tick_pct, int len_span, int flip_pct);
		cmd_t c;
		int pick;
		if ($urandom_range(0, 99) < flip_pct) pin_level = ~pin_level;
		c.button_level = pin_level;
		pick = $urandom_range(0, 99);
		if (pick < tick_pct) begin
			c.action = ACT_TICK;
		end else begin
			pick = $urandom_range(0, 99);
			if (pick < 30) c.action = ACT_START_TIMEOUT;
			else if (pick < 55) c.action = ACT_ACK_FLAGS;
			else if (pick < 80) c.action = ACT_START_BLINK;
			else if (pick < 95) c.action = ACT_ACK_BUTTON;
			else c.action = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		end
		c.timeout_select = ($urandom_range(0, 9) == 0) ? SEL_NONE
			: 2'($urandom_range(0, TIMEOUTS - 1));
		c.timeout_length = ($urandom_range(0, 15) == 0) ? 16'($urandom)
			: 16'($urandom_range(0, len_span));
		c.flag_clear_mask = 3'($urandom);
		c.blink_led = 1'($urandom);
		c.blink_count = ($urandom_range(0, 7) == 0) ? 8'($urandom)
			: 8'($urandom_range(0, 3));
		return c;
	endfunction

	// change valid only when it really changes, so one step never sees two drives
	task automatic drive_valid(bit v);
		if (vld_want != v) begin
			vld_want = v;
			cmd_valid <= v;
		end
	endtask

	task automatic send_request(cmd_t c);
		int gap;
		gap = draw_wait();
		if (gap != 0) begin
			drive_valid(1'b0);
			repeat (gap) @(posedge clk);
		end
		cmd <= c;
		drive_valid(1'b1);
		do @(posedge clk); while (!cmd_ready);
		pending_status.push_back(apply_request(c));
		requests_sent++;
		if (c.action == ACT_TICK) ticks_sent++;
	endtask

	task automatic wait_idle();
		drive_valid(1'b0);
		while (pending_status.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic apb_access(bit wr, reg_idx_t idx, logic [31:0] wdata,
			output logic [31:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= wr;
		paddr <= ADDR_W'(int'(idx) * 4);
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		@(posedge clk);
	endtask

	task automatic write_reg(reg_idx_t idx, logic [31:0] v);
		logic [31:0] unused;
		apb_access(1'b1, idx, v, unused);
		set_cfg(idx, v);
	endtask

	task automatic check_regs();
		logic [31:0] got;
		int i;
		for (i = 0; i <= int'(REG_FOREVER); i++) begin
			apb_access(1'b0, reg_idx_t'(i), '0, got);
			if (got !== cfg_value(reg_idx_t'(i))) begin
				$display("%0t: register %0d expected %0h got %0h", $time, i,
					cfg_value(reg_idx_t'(i)), got);
				mismatches++;
			end
		end
	endtask

	task automatic program_regs(input logic [15:0] pa, pb, pc, input logic [7:0] deb, rep,
			input logic [15:0] on_t, off_t, input logic fe);
		wait_idle();
		write_reg(REG_PERIOD_A, 32'(pa));
		write_reg(REG_PERIOD_B, 32'(pb));
		write_reg(REG_PERIOD_C, 32'(pc));
		write_reg(REG_DEBOUNCE, 32'(deb));
		write_reg(REG_REPEAT, 32'(rep));
		write_reg(REG_ON, 32'(on_t));
		write_reg(REG_OFF, 32'(off_t));
		write_reg(REG_FOREVER, 32'(fe));
		check_regs();
		settings_used++;
	endtask

	// ignored requests do not count towards the total
	task automatic run_random(int count, int tick_pct, int len_span, int flip_pct);
		cmd_t c;
		int done_cnt;
		done_cnt = 0;
		while (done_cnt < count) begin
			if ($urandom_range(0, 49) == 0) steady = ~steady;
			c = random_request(tick_pct, len_span, flip_pct);
			send_request(c);
			if (c.action <= ACT_ACK_BUTTON &&
					!(c.action == ACT_START_TIMEOUT && c.timeout_select == SEL_NONE))
				done_cnt++;
		end
	endtask

	task automatic test_reset_values();
		check_regs();
	endtask

	// unused codes, stray select, zero and full lengths, shared blink phase
	task automatic test_directed();
		int a;
		program_regs(16'd0, 16'd1, 16'd2, 8'd0, 8'd0, 16'd1, 16'd2, 1'b0);
		for (a = int'(ACT_SPARE_LO); a <= int'(ACT_SPARE_HI); a++)
			send_request(req(3'(a), 1'b1, 2'd3, 16'hFFFF, 3'd7, 1'b1, 8'hFF));
		send_request(req(ACT_TICK, 1'b1, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_TIMEOUT, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_TIMEOUT, 1'b0, 2'd1, 16'hFFFF, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_TIMEOUT, 1'b0, 2'd2, 16'd2, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_TIMEOUT, 1'b0, SEL_NONE, 16'd1, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_TICK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_ACK_FLAGS, 1'b0, 2'd0, 16'd0, 3'd5, 1'b0, 8'd0));
		send_request(req(ACT_START_BLINK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_BLINK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b1, 8'hFF));
		send_request(req(ACT_TICK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_TICK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_TICK, 1'b1, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_ACK_BUTTON, 1'b1, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_ACK_FLAGS, 1'b1, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_ACK_FLAGS, 1'b1, 2'd0, 16'd0, 3'd7, 1'b0, 8'd0));
		send_request(req(ACT_TICK, 1'b1, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_TICK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
		send_request(req(ACT_START_BLINK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd1));
		repeat (3) send_request(req(ACT_TICK, 1'b0, 2'd0, 16'd0, 3'd0, 1'b0, 8'd0));
	endtask

	task automatic test_fast_counters();
		program_regs(16'd1, 16'd3, 16'd7, 8'd3, 8'd5, 16'd2, 16'd3, 1'b0);
		run_random(340, 70, 12, 10);
	endtask

	// zero periods, debounce and repeat; long tick runs let the repeat counter wrap
	task automatic test_zero_settings();
		program_regs(16'd0, 16'd0, 16'd0, 8'd0, 8'd0, 16'd0, 16'd0, 1'b1);
		run_random(280, 96, 4, 20);
	endtask

	task automatic test_extreme_settings();
		program_regs(16'hFFFF, 16'hFFFF, 16'hFFFF, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b0);
		run_random(150, 60, 40, 3);
	endtask

	task automatic test_mixed_settings();
		repeat (3) begin
			program_regs(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
				16'($urandom_range(1, 40)), 8'($urandom_range(1, 8)),
				8'($urandom_range(1, 30)), 16'($urandom_range(1, 12)),
				16'($urandom_range(1, 12)), 1'($urandom));
			run_random(125, 75, 20, 6);
		end
	endtask

	// result checking and receiver back-pressure
	always @(posedge clk) begin : status_check
		rsp_t want;
		if (arst_n) begin
			if (rsp_valid && rsp_ready) begin
				if (pending_status.size() == 0) begin
					$display("%0t: status with no request waiting, got %p", $time, rsp);
					mismatches++;
				end else begin
					want = pending_status.pop_front();
					check_field("period_flags", 16'(want.period_flags),
						16'(rsp.period_flags));
					check_field("timeouts_done", 16'(want.timeouts_done),
						16'(rsp.timeouts_done));
					check_field("button_pressed", 16'(want.button_pressed),
						16'(rsp.button_pressed));
					check_field("press_time", want.press_time, rsp.press_time);
					check_field("repeat_ready", 16'(want.repeat_ready),
						16'(rsp.repeat_ready));
					check_field("red_light", 16'(want.red_light), 16'(rsp.red_light));
					check_field("green_light", 16'(want.green_light),
						16'(rsp.green_light));
				end
				status_checked++;
				rsp_hold = draw_wait();
				if (rsp_hold != 0) rsp_ready <= 1'b0;
			end else if (!rsp_ready) begin
				if (rsp_hold <= 1) rsp_ready <= 1'b1;
				else rsp_hold--;
			end
		end
	end

	// watchdog on cycles without any handshake
	always @(posedge clk) begin
		if ((cmd_valid && cmd_ready) || (rsp_valid && rsp_ready) || psel || !arst_n) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no progress for %0d cycles", $time, idle_cycles);
			$display("simulation failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		// reset edge at time zero so the flops clear before the first clock
		arst_n <= 1'b0;
		reset_model();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_directed();
		test_fast_counters();
		test_zero_settings();
		test_extreme_settings();
		test_mixed_settings();
		wait_idle();
		$display("Covered %0d requests (%0d ticks) across %0d register settings,",
			requests_sent, ticks_sent, settings_used);
		$display("%0d statuses checked, %0d mismatches.", status_checked, mismatches);
		if (mismatches == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

endmodule
